### hdl/ffsa_pkg.sv
`timescale 1ns / 1ps
package ffsa_pkg;

    localparam int PID_W      = 16;
    localparam int SIZE_W     = 21;
    localparam int GADDR_W    = 20;
    localparam int BASE_W     = 20;
    localparam int LEN_W      = 21;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 21;
    localparam int ADDR_BITS  = GADDR_W;
    localparam int PID_BITS   = PID_W;

    localparam logic [BASE_W-1:0] BASE_RESET = '0;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 21'd1048576;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_BASE   = 4'd0,
        CFG_REGION_LENGTH = 4'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FREAD,
        ST_FCHK,
        ST_FSPLIT,
        ST_FSHRD,
        ST_FSHWR,
        ST_BSTART,
        ST_BREAD,
        ST_BCHK,
        ST_BSHIFT,
        ST_BSRD,
        ST_BSWR,
        ST_BINS,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [PID_W-1:0]  proc_id;
        logic [SIZE_W-1:0] request_size;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [GADDR_W-1:0] granted_address;
    } t_out_item;

endpackage

### hdl/ffsa_alu.sv
`timescale 1ns / 1ps
module ffsa_alu #(
    parameter int W = 21
) (
    input  ffsa_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_res,
    output logic              o_borrow
);
    import ffsa_pkg::*;

    logic [W:0] sum;

    // carry out on add, borrow on subtract (a < b)
    always_comb begin
        unique case (i_op)
            ALU_ADD: sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: sum = {1'b0, i_a} - {1'b0, i_b};
            default: sum = '0;
        endcase
    end

    assign o_res    = sum[W-1:0];
    assign o_borrow = sum[W];

endmodule

### hdl/ffsa_tables.sv
`timescale 1ns / 1ps
module ffsa_tables #(
    parameter int FREE_SLOTS = 16,
    parameter int BUSY_SLOTS = 16,
    parameter int FREE_W     = 41,
    parameter int BUSY_W     = 57
) (
    input  logic                          i_clk,
    input  logic                          i_free_we,
    input  logic [$clog2(FREE_SLOTS)-1:0] i_free_waddr,
    input  logic [FREE_W-1:0]             i_free_wdata,
    input  logic [$clog2(FREE_SLOTS)-1:0] i_free_raddr,
    output logic [FREE_W-1:0]             o_free_rdata,
    input  logic                          i_busy_we,
    input  logic [$clog2(BUSY_SLOTS)-1:0] i_busy_waddr,
    input  logic [BUSY_W-1:0]             i_busy_wdata,
    input  logic [$clog2(BUSY_SLOTS)-1:0] i_busy_raddr,
    output logic [BUSY_W-1:0]             o_busy_rdata
);

    logic [FREE_W-1:0] free_mem [FREE_SLOTS];
    logic [BUSY_W-1:0] busy_mem [BUSY_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_free_we) begin
            free_mem[i_free_waddr] <= i_free_wdata;
        end
        o_free_rdata <= free_mem[i_free_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_busy_we) begin
            busy_mem[i_busy_waddr] <= i_busy_wdata;
        end
        o_busy_rdata <= busy_mem[i_busy_raddr];
    end

endmodule

### hdl/first_fit_segment_allocator.sv
`timescale 1ns / 1ps
// Rejected requests and requests that meet an empty free table go straight to the result.
//   Others scan the free table; no fit ends the scan with a result, else the fitting entry is
//   split or removed, the occupied table is searched and shifted, and the new entry inserted.
// One request at a time; each table entry visited passes through the
//   single subtract/add unit and the registered table read ports.
// Reset (synchronous, active low) and any region write pass through a state that loads the free head.
module first_fit_segment_allocator #(
    parameter int FREE_SLOTS = 16,
    parameter int BUSY_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ffsa_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ffsa_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ffsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ffsa_pkg::*;

    localparam int FI  = $clog2(FREE_SLOTS);
    localparam int BI  = $clog2(BUSY_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int BCW = $clog2(BUSY_SLOTS + 1);
    localparam int SW  = ADDR_BITS + 1;
    localparam int CW  = (SW > SIZE_W) ? SW : SIZE_W;
    localparam logic [SW-1:0] SPACE = {1'b1, {ADDR_BITS{1'b0}}};

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [SW-1:0]        size;
    } t_free_ent;

    typedef struct packed {
        logic [PID_BITS-1:0]  pid;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_W-1:0]    size;
    } t_busy_ent;

    localparam int FREE_W = $bits(t_free_ent);
    localparam int BUSY_W = $bits(t_busy_ent);

    t_state               r_state, n_state;
    logic [BASE_W-1:0]    r_base, n_base;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [FCW-1:0]       r_fcount, n_fcount;
    logic [BCW-1:0]       r_bcount, n_bcount;
    logic [FI-1:0]        r_idx, n_idx;
    logic [BI-1:0]        r_bidx, n_bidx;
    logic [BI-1:0]        r_sh, n_sh;
    logic [PID_BITS-1:0]  r_pid, n_pid;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [SW-1:0]        r_diff, n_diff;
    t_status              r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 in_acc, cfg_hit, bad_in, bfull, out_go;
    logic [PID_BITS-1:0]  pid_in;
    logic [FCW-1:0]       fidx_next;
    logic [BCW-1:0]       bidx_next;
    logic [ADDR_BITS-1:0] base_eff;
    logic [SW-1:0]        room, len_eff;
    logic [CW-1:0]        len_ext;

    t_alu_op              alu_op;
    logic [CW-1:0]        alu_a, alu_b, alu_res;
    logic                 alu_borrow;

    logic                 free_we, busy_we;
    logic [FI-1:0]        free_waddr, free_raddr;
    logic [BI-1:0]        busy_waddr, busy_raddr;
    t_free_ent            free_wdata, frd;
    t_busy_ent            busy_wdata, brd;
    logic [FREE_W-1:0]    free_rdata;
    logic [BUSY_W-1:0]    busy_rdata;

    // hold requests while a register write is offered
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_REGION_BASE ||
                                     i_cfg_index == CFG_REGION_LENGTH);
    assign pid_in  = PID_BITS'(i_in_data.proc_id);
    assign bad_in  = (pid_in == '0) || (i_in_data.request_size == '0);
    assign bfull   = (r_bcount == BCW'(BUSY_SLOTS));
    assign out_go  = !r_out_valid || i_out_ready;

    assign fidx_next = FCW'(r_idx) + FCW'(1);
    assign bidx_next = BCW'(r_bidx) + BCW'(1);

    // clip the region so it does not extend past the top of the address space
    assign base_eff = ADDR_BITS'(r_base);
    assign room     = SPACE - {1'b0, base_eff};
    assign len_ext  = CW'(r_len);
    assign len_eff  = (len_ext > CW'(room)) ? room : SW'(len_ext);

    assign frd = t_free_ent'(free_rdata);
    assign brd = t_busy_ent'(busy_rdata);

    ffsa_alu #(.W(CW)) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    ffsa_tables #(
        .FREE_SLOTS (FREE_SLOTS),
        .BUSY_SLOTS (BUSY_SLOTS),
        .FREE_W     (FREE_W),
        .BUSY_W     (BUSY_W)
    ) u_tables (
        .i_clk        (i_clk),
        .i_free_we    (free_we),
        .i_free_waddr (free_waddr),
        .i_free_wdata (free_wdata),
        .i_free_raddr (free_raddr),
        .o_free_rdata (free_rdata),
        .i_busy_we    (busy_we),
        .i_busy_waddr (busy_waddr),
        .i_busy_wdata (busy_wdata),
        .i_busy_raddr (busy_raddr),
        .o_busy_rdata (busy_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (bad_in || bfull || r_fcount == '0) ? ST_RESP : ST_FREAD;
                end
            end
            ST_FREAD: n_state = ST_FCHK;
            ST_FCHK: begin
                if (!alu_borrow) begin
                    if (alu_res != '0) begin
                        n_state = ST_FSPLIT;
                    end else begin
                        n_state = (fidx_next < r_fcount) ? ST_FSHRD : ST_BSTART;
                    end
                end else begin
                    n_state = (fidx_next == r_fcount) ? ST_RESP : ST_FREAD;
                end
            end
            ST_FSPLIT: n_state = ST_BSTART;
            ST_FSHRD:  n_state = ST_FSHWR;
            // the count has already dropped by one here
            ST_FSHWR:  n_state = (fidx_next < r_fcount) ? ST_FSHRD : ST_BSTART;
            ST_BSTART: n_state = (r_bcount == '0) ? ST_BSHIFT : ST_BREAD;
            ST_BREAD:  n_state = ST_BCHK;
            ST_BCHK: begin
                if (alu_borrow && bidx_next != r_bcount) begin
                    n_state = ST_BREAD;
                end else begin
                    n_state = ST_BSHIFT;
                end
            end
            ST_BSHIFT: n_state = (BCW'(r_bidx) < r_bcount) ? ST_BSRD : ST_BINS;
            ST_BSRD:   n_state = ST_BSWR;
            ST_BSWR:   n_state = ((r_sh - BI'(1)) > r_bidx) ? ST_BSRD : ST_BINS;
            ST_BINS:   n_state = ST_RESP;
            ST_RESP:   n_state = out_go ? ST_IDLE : ST_RESP;
            default:   n_state = ST_INIT;
        endcase
        if (cfg_hit) begin
            n_state = ST_INIT;
        end
    end

    // shared unit and table controls
    always_comb begin
        alu_op     = ALU_SUB;
        alu_a      = CW'(frd.size);
        alu_b      = CW'(r_size);
        free_we    = 1'b0;
        free_waddr = r_idx;
        free_wdata = frd;
        free_raddr = r_idx;
        busy_we    = 1'b0;
        busy_waddr = r_sh;
        busy_wdata = brd;
        busy_raddr = r_bidx;
        unique case (r_state)
            ST_INIT: begin
                free_we    = 1'b1;
                free_waddr = '0;
                free_wdata = '{addr: base_eff, size: len_eff};
            end
            ST_FSPLIT: begin
                alu_op     = ALU_ADD;
                alu_a      = CW'(r_addr);
                alu_b      = CW'(r_size);
                free_we    = 1'b1;
                free_wdata = '{addr: ADDR_BITS'(alu_res), size: r_diff};
            end
            ST_FSHRD: free_raddr = r_idx + FI'(1);
            ST_FSHWR: free_we = 1'b1;
            ST_BCHK: begin
                alu_a = CW'(brd.addr);
                alu_b = CW'(r_addr);
            end
            ST_BSRD: busy_raddr = r_sh - BI'(1);
            ST_BSWR: busy_we = 1'b1;
            ST_BINS: begin
                busy_we    = 1'b1;
                busy_waddr = r_bidx;
                busy_wdata = '{pid: r_pid, addr: r_addr, size: r_size};
            end
            default: ;
        endcase
    end

    // datapath and counters
    always_comb begin
        n_base      = r_base;
        n_len       = r_len;
        n_fcount    = r_fcount;
        n_bcount    = r_bcount;
        n_idx       = r_idx;
        n_bidx      = r_bidx;
        n_sh        = r_sh;
        n_pid       = r_pid;
        n_size      = r_size;
        n_addr      = r_addr;
        n_diff      = r_diff;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_INIT: begin
                n_fcount = (len_eff != '0) ? FCW'(1) : '0;
                n_bcount = '0;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_pid  = pid_in;
                    n_size = i_in_data.request_size;
                    n_idx  = '0;
                    priority if (bad_in) begin
                        n_status = STAT_BAD;
                    end else if (bfull) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_status = STAT_NOFIT;
                    end
                end
            end
            ST_FCHK: begin
                if (!alu_borrow) begin
                    n_addr = frd.addr;
                    n_diff = SW'(alu_res);
                    if (alu_res == '0) begin
                        n_fcount = r_fcount - FCW'(1);
                    end
                end else if (fidx_next != r_fcount) begin
                    n_idx = r_idx + FI'(1);
                end
            end
            ST_FSHWR:  n_idx = r_idx + FI'(1);
            ST_BSTART: n_bidx = '0;
            ST_BCHK: begin
                if (alu_borrow) begin
                    n_bidx = r_bidx + BI'(1);
                end
            end
            ST_BSHIFT: n_sh = BI'(r_bcount);
            ST_BSWR:   n_sh = r_sh - BI'(1);
            ST_BINS: begin
                n_bcount = r_bcount + BCW'(1);
                n_status = STAT_OK;
            end
            ST_RESP: begin
                if (out_go) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    n_out.granted_address = (r_status == STAT_OK) ? GADDR_W'(r_addr) : '0;
                end
            end
            default: ;
        endcase
        if (i_cfg_valid && i_cfg_index == CFG_REGION_BASE) begin
            n_base = i_cfg_data[BASE_W-1:0];
        end
        if (i_cfg_valid && i_cfg_index == CFG_REGION_LENGTH) begin
            n_len = i_cfg_data[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_base      <= BASE_RESET;
            r_len       <= LEN_RESET;
            r_fcount    <= '0;
            r_bcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_len       <= n_len;
            r_fcount    <= n_fcount;
            r_bcount    <= n_bcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_bidx   <= n_bidx;
        r_sh     <= n_sh;
        r_pid    <= n_pid;
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_diff   <= n_diff;
        r_status <= n_status;
        r_out    <= n_out;
    end

`ifndef SYNTH
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fcount <= FCW'(FREE_SLOTS)) && (r_bcount <= BCW'(BUSY_SLOTS)))
        else $error("table count out of range");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_hit) |=> (r_state != ST_IDLE))
        else $error("accepted request did not start");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BINS && !cfg_hit) |=> (r_bcount == $past(r_bcount) + 1'b1))
        else $error("occupied count not advanced on insert");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != STAT_OK) |-> (r_out.granted_address == '0))
        else $error("failed request carries an address");

    a_free_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_INIT) |=> (r_fcount <= $past(r_fcount)))
        else $error("free count grew outside init");
`endif

endmodule
